/* src/assert_macros.svh */
// assertion macros for the matrix inverse block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* src/minv_pkg.sv */
// types and constants shared by the 4x4 matrix inverse block
// no dependencies
package minv_pkg;
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MINOR,
      ST_DET,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam int unsigned NUM_ELEMS = 16;
   localparam int unsigned IDX_W = 4;
endpackage

/* src/minv_if.sv */
// valid/ready channel carrying a payload struct-free set of fields
// depends on nothing
interface minv_req_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic signed [DW-1:0] elem_value;
   logic [3:0] elem_index;
   logic load_last;
   modport source (output valid, elem_value, elem_index, load_last, input ready);
   modport sink (input valid, elem_value, elem_index, load_last, output ready);
endinterface

interface minv_rsp_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic signed [DW-1:0] inv_value;
   logic [3:0] inv_index;
   logic singular;
   logic out_last;
   modport source (output valid, inv_value, inv_index, singular, out_last, input ready);
   modport sink (input valid, inv_value, inv_index, singular, out_last, output ready);
endinterface

/* src/matrix_inverse_4x4.sv */
// 4x4 matrix inverse by adjugate, signed fixed point, one shared multiplier and divider
// depends on minv_pkg, minv_if.sv, assert_macros.svh
//
//  channel | dir | fields
//  req     | in  | elem_value, elem_index, load_last
//  rsp     | out | inv_value, inv_index, singular, out_last
//
// loading accepts one element per cycle; a last element starts a run of 196 products
// (192 for the minors, 4 for the determinant) through a radix-4 shift-add multiplier,
// then 16 restoring divisions (Q16.16 by default); a singular matrix emits one result
// a cycle instead, while rsp does not stall
// req is not ready from the last element until the sixteenth result is registered;
// rsp stalls hold the result register and pause the run
// synchronous active high reset clears control state only
`include "assert_macros.svh"
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   minv_req_if.sink req,
   minv_rsp_if.source rsp
);
   import minv_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;              // product magnitude width
   localparam int NW = DW + FRAC_BITS;      // dividend width
   localparam int MCW = $clog2(DW / 2 + 1);
   localparam int DCW = $clog2(NW + 1);
   localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

   logic signed [DW-1:0] mat_ff [NUM_ELEMS];
   logic signed [DW-1:0] cof_ff [NUM_ELEMS];

   state_type state_ff, state_in;

   // sequencing counters
   logic [3:0] cidx_ff, cidx_in;     // cofactor / output index
   logic [2:0] term_ff, term_in;     // term of the minor, 0..5
   logic       half_ff, half_in;     // first or second product of a triple
   logic [1:0] didx_ff, didx_in;     // determinant term
   logic       mgo_ff, mgo_in;       // issue a product this cycle
   logic       dgo_ff, dgo_in;       // issue a division this cycle

   logic signed [DW-1:0] acc_ff, acc_in;   // minor or determinant accumulator
   logic signed [DW-1:0] part_ff, part_in; // first product of a triple
   logic signed [DW-1:0] det_ff, det_in;
   logic signed [DW-1:0] msum, mdiff, mterm;
   logic signed [DW-1:0] tcof;             // cofactor for the output index
   logic                 cof_we;
   logic signed [DW-1:0] cof_wd;

   // shared multiplier: radix-4 shift add over the magnitudes
   logic          mbusy_ff, mbusy_in;
   logic          mdone_ff, mdone_in;
   logic [MCW-1:0] mcnt_ff, mcnt_in;
   logic [PW-1:0] mprod_ff, mprod_in;
   logic [PW-1:0] mmc_ff, mmc_in;     // shifted multiplicand
   logic [DW-1:0] mmp_ff, mmp_in;     // multiplier bits
   logic          mneg_ff, mneg_in;
   logic signed [DW-1:0] mop_a, mop_b, mres;

   // shared divider
   logic          dbusy_ff, dbusy_in;
   logic          ddone_ff, ddone_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [NW-1:0] dnum_ff, dnum_in;
   logic [DW:0]   drem_ff, drem_in;
   logic [DW-1:0] dden_ff, dden_in;
   logic [NW-1:0] dquo_ff, dquo_in;
   logic          dneg_ff, dneg_in;
   logic signed [DW-1:0] dres;

   // result register
   logic          ovalid_ff, ovalid_in;
   logic signed [DW-1:0] oval_ff, oval_in;
   logic [3:0]    oidx_ff, oidx_in;
   logic          osing_ff, osing_in;
   logic          olast_ff, olast_in;

   logic req_fire, rsp_free;

   function automatic logic [DW-1:0] magf(input logic signed [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic signed [DW-1:0] satadd(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
      return s[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] satsub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
      return s[DW-1:0];
   endfunction

   // incoming element clamped into the data range
   function automatic logic signed [DW-1:0] clamp_in(input logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > 64'(VMAX)) return VMAX;
      if (w < 64'(VMIN)) return VMIN;
      return DW'(w);
   endfunction

   // row and column of the 3x3 minor element (mr, mc) for cofactor (r, c)
   function automatic logic [3:0] maddr(input logic [3:0] k, input logic [1:0] mr,
                                        input logic [1:0] mc);
      logic [1:0] r, c;
      r = (mr >= k[3:2]) ? mr + 2'd1 : mr;
      c = (mc >= k[1:0]) ? mc + 2'd1 : mc;
      return {r, c};
   endfunction

   // minor term operand positions: term t, factor f (0..2) -> {row, col}
   function automatic logic [3:0] tpos(input logic [2:0] t, input logic [1:0] f);
      logic [3:0] p;
      p = 4'd0;
      case (t)
         3'd0: p = (f == 2'd0) ? 4'h0 : (f == 2'd1) ? 4'h5 : 4'hA;
         3'd1: p = (f == 2'd0) ? 4'h1 : (f == 2'd1) ? 4'h6 : 4'h8;
         3'd2: p = (f == 2'd0) ? 4'h2 : (f == 2'd1) ? 4'h4 : 4'h9;
         3'd3: p = (f == 2'd0) ? 4'h8 : (f == 2'd1) ? 4'h5 : 4'h2;
         3'd4: p = (f == 2'd0) ? 4'h9 : (f == 2'd1) ? 4'h6 : 4'h0;
         default: p = (f == 2'd0) ? 4'hA : (f == 2'd1) ? 4'h4 : 4'h1;
      endcase
      return p;
   endfunction

   function automatic logic signed [DW-1:0] melem(input logic [3:0] k,
                                                   input logic [3:0] p);
      return mat_ff[maddr(k, p[3:2], p[1:0])];
   endfunction

   // product saturation
   always_comb begin
      logic [PW-1:0] sh;
      sh = mprod_ff >> FRAC_BITS;
      if (mneg_ff) begin
         if (sh > PW'(VMAX) + PW'(1)) mres = VMIN;
         else mres = DW'(~sh + 1'b1);
      end else begin
         if (sh > PW'(VMAX)) mres = VMAX;
         else mres = DW'(sh);
      end
   end

   // quotient saturation
   always_comb begin
      if (dneg_ff) begin
         if (dquo_ff > NW'(VMAX) + NW'(1)) dres = VMIN;
         else dres = DW'(~dquo_ff + 1'b1);
      end else begin
         if (dquo_ff > NW'(VMAX)) dres = VMAX;
         else dres = DW'(dquo_ff);
      end
   end

   // operand selection for the multiplier
   always_comb begin
      mop_a = '0;
      mop_b = '0;
      if (state_ff == ST_MINOR) begin
         if (!half_ff) begin
            mop_a = melem(cidx_ff, tpos(term_ff, 2'd0));
            mop_b = melem(cidx_ff, tpos(term_ff, 2'd1));
         end else begin
            mop_a = part_ff;
            mop_b = melem(cidx_ff, tpos(term_ff, 2'd2));
         end
      end else begin
         mop_a = mat_ff[{2'd0, didx_ff}];
         mop_b = cof_ff[{2'd0, didx_ff}];
      end
   end

   assign msum = satadd(acc_ff, mres);
   assign mdiff = satsub(acc_ff, mres);
   assign mterm = (term_ff < 3'd3) ? msum : mdiff;
   // the inverse is the transposed cofactor matrix
   assign tcof = cof_ff[{cidx_ff[1:0], cidx_ff[3:2]}];

   assign req.ready = (state_ff == ST_LOAD);
   assign req_fire = req.valid && req.ready;
   assign rsp_free = !ovalid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (req_fire && req.load_last) state_in = ST_MINOR;
         ST_MINOR:
            if (mdone_ff && half_ff && term_ff == 3'd5 && cidx_ff == 4'd15)
               state_in = ST_DET;
         ST_DET:
            if (mdone_ff && didx_ff == 2'd3) state_in = (msum == '0) ? ST_OUT : ST_DIV;
         ST_DIV: if (ddone_ff) state_in = ST_OUT;
         ST_OUT:
            if (rsp_free) begin
               if (cidx_ff == 4'd15) state_in = ST_LOAD;
               else if (det_ff != '0) state_in = ST_DIV;
            end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and sequencing
   always_comb begin
      cidx_in = cidx_ff; term_in = term_ff; half_in = half_ff; didx_in = didx_ff;
      acc_in = acc_ff; part_in = part_ff; det_in = det_ff;
      mgo_in = 1'b0; dgo_in = 1'b0;
      cof_we = 1'b0; cof_wd = mterm;
      ovalid_in = ovalid_ff && !rsp.ready;
      oval_in = oval_ff; oidx_in = oidx_ff; osing_in = osing_ff; olast_in = olast_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req.load_last) begin
               cidx_in = '0; term_in = '0; half_in = 1'b0; acc_in = '0;
               mgo_in = 1'b1;
            end
         end
         ST_MINOR: begin
            if (mdone_ff) begin
               mgo_in = 1'b1;
               if (!half_ff) begin
                  part_in = mres; half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  if (term_ff == 3'd5) begin
                     cof_we = 1'b1;
                     if (cidx_ff[2] ^ cidx_ff[0])
                        cof_wd = (mterm == VMIN) ? VMAX : -mterm;
                     term_in = '0; acc_in = '0; didx_in = '0;
                     // wraps to zero after the last minor
                     cidx_in = cidx_ff + 4'd1;
                  end else begin
                     term_in = term_ff + 3'd1;
                     acc_in = mterm;
                  end
               end
            end
         end
         ST_DET: begin
            if (mdone_ff) begin
               acc_in = msum;
               if (didx_ff != 2'd3) begin
                  didx_in = didx_ff + 2'd1;
                  mgo_in = 1'b1;
               end else begin
                  det_in = msum; cidx_in = '0;
                  dgo_in = (msum != '0);
               end
            end
         end
         ST_DIV: ;
         ST_OUT: begin
            if (rsp_free) begin
               ovalid_in = 1'b1;
               oidx_in = cidx_ff;
               osing_in = (det_ff == '0);
               olast_in = (cidx_ff == 4'd15);
               if (det_ff == '0) oval_in = (tcof == '0) ? '0 : (tcof[DW-1] ? VMIN : VMAX);
               else oval_in = dres;
               if (cidx_ff != 4'd15) begin
                  cidx_in = cidx_ff + 4'd1;
                  dgo_in = (det_ff != '0);
               end
            end
         end
         default: ;
      endcase
   end

   // multiplier and divider iterations
   always_comb begin
      logic [DW-1:0] am, bm;
      logic [DW:0] tr;
      am = magf(mop_a); bm = magf(mop_b);
      mbusy_in = mbusy_ff; mdone_in = 1'b0; mcnt_in = mcnt_ff;
      mprod_in = mprod_ff; mmc_in = mmc_ff; mmp_in = mmp_ff; mneg_in = mneg_ff;
      if (mgo_ff) begin
         mbusy_in = 1'b1; mcnt_in = '0; mprod_in = '0;
         mmc_in = PW'(am); mmp_in = bm; mneg_in = mop_a[DW-1] ^ mop_b[DW-1];
      end else if (mbusy_ff) begin
         mprod_in = mprod_ff + (mmp_ff[0] ? mmc_ff : '0) + (mmp_ff[1] ? (mmc_ff << 1) : '0);
         mmc_in = mmc_ff << 2;
         mmp_in = mmp_ff >> 2;
         mcnt_in = mcnt_ff + 1'b1;
         if (mcnt_ff == MCW'(DW / 2 - 1)) begin
            mbusy_in = 1'b0; mdone_in = 1'b1;
         end
      end
      dbusy_in = dbusy_ff; ddone_in = 1'b0; dcnt_in = dcnt_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff; dquo_in = dquo_ff;
      dneg_in = dneg_ff;
      tr = '0;
      if (dgo_ff) begin
         dbusy_in = 1'b1; dcnt_in = '0; drem_in = '0; dquo_in = '0;
         dnum_in = {magf(tcof), {FRAC_BITS{1'b0}}};
         dden_in = magf(det_ff);
         dneg_in = tcof[DW-1] ^ det_ff[DW-1];
      end else if (dbusy_ff) begin
         tr = {drem_ff[DW-1:0], dnum_ff[NW-1]};
         dnum_in = dnum_ff << 1;
         if (tr >= {1'b0, dden_ff}) begin
            drem_in = tr - {1'b0, dden_ff};
            dquo_in = {dquo_ff[NW-2:0], 1'b1};
         end else begin
            drem_in = tr;
            dquo_in = {dquo_ff[NW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 1'b1;
         if (dcnt_ff == DCW'(NW - 1)) begin
            dbusy_in = 1'b0; ddone_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) mat_ff[req.elem_index] <= clamp_in(req.elem_value);
      if (cof_we) cof_ff[cidx_ff] <= cof_wd;
      acc_ff <= acc_in; part_ff <= part_in; det_ff <= det_in;
      mprod_ff <= mprod_in; mmc_ff <= mmc_in; mmp_ff <= mmp_in; mneg_ff <= mneg_in;
      mcnt_ff <= mcnt_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in; dquo_ff <= dquo_in;
      dneg_ff <= dneg_in; dcnt_ff <= dcnt_in;
      oval_ff <= oval_in; oidx_ff <= oidx_in; osing_ff <= osing_in; olast_ff <= olast_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         cidx_ff <= '0; term_ff <= '0; half_ff <= 1'b0; didx_ff <= '0;
         mgo_ff <= 1'b0; dgo_ff <= 1'b0;
         mbusy_ff <= 1'b0; mdone_ff <= 1'b0; dbusy_ff <= 1'b0; ddone_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cidx_ff <= cidx_in; term_ff <= term_in; half_ff <= half_in; didx_ff <= didx_in;
         mgo_ff <= mgo_in; dgo_ff <= dgo_in;
         mbusy_ff <= mbusy_in; mdone_ff <= mdone_in;
         dbusy_ff <= dbusy_in; ddone_ff <= ddone_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.inv_value = 32'(oval_ff);
   assign rsp.inv_index = oidx_ff;
   assign rsp.singular = osing_ff;
   assign rsp.out_last = olast_ff;

   `ASSERT_NEVER(a_units_exclusive, clock, reset, mbusy_ff && dbusy_ff)
   `ASSERT_NEVER(a_no_load_in_run, clock, reset, req_fire && state_ff != ST_LOAD)
   `ASSERT_IMPL(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready |=> $stable(rsp.inv_value))
   `ASSERT_IMPL(a_last_idx, clock, reset, rsp.valid && rsp.out_last |-> rsp.inv_index == 4'd15)
endmodule
